@@ sv/pidc_pkg.sv @@
package pidc_pkg;

	localparam int DataW = 32;
	localparam int StepW = 31;
	localparam int MulW  = DataW + 1;
	localparam int ProdW = 2 * MulW;
	localparam int WideW = DataW + 2;
	localparam int DivW  = 2 * DataW;
	localparam int CfgIdxW = 3;

	localparam logic signed [DataW-1:0] SatMax = {1'b0, {(DataW-1){1'b1}}};
	localparam logic signed [DataW-1:0] SatMin = {1'b1, {(DataW-1){1'b0}}};

	localparam logic [StepW-1:0]        RstStepTime = StepW'(655);
	localparam logic signed [DataW-1:0] RstOutMin   = SatMin;
	localparam logic signed [DataW-1:0] RstOutMax   = SatMax;

	// configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		REG_GAIN_P    = 3'd0,
		REG_GAIN_I    = 3'd1,
		REG_GAIN_D    = 3'd2,
		REG_STEP_TIME = 3'd3,
		REG_OUT_MIN   = 3'd4,
		REG_OUT_MAX   = 3'd5
	} reg_idx_t;

	// handshake between sequencer and divider
	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic done;
	} div_sts_t;

	// saturate a wide signed value to 32 bits
	function automatic logic signed [DataW-1:0] sat_wide(input logic signed [WideW-1:0] v);
		logic [WideW-DataW:0] top;
		top = v[WideW-1:DataW-1];
		if (&top || ~|top) begin
			return v[DataW-1:0];
		end
		return v[WideW-1] ? SatMin : SatMax;
	endfunction

	// floor a product by 2^16, then saturate to 32 bits
	function automatic logic signed [DataW-1:0] sat_q16(input logic signed [ProdW-1:0] p);
		logic signed [ProdW-1:0] sh;
		logic [ProdW-DataW:0]    top;
		sh  = p >>> 16;
		top = sh[ProdW-1:DataW-1];
		if (&top || ~|top) begin
			return sh[DataW-1:0];
		end
		return sh[ProdW-1] ? SatMin : SatMax;
	endfunction

endpackage

@@ sv/pidc_mul.sv @@
module pidc_mul (
	input  logic                                clk,
	input  logic signed [pidc_pkg::MulW-1:0]    a,
	input  logic signed [pidc_pkg::MulW-1:0]    b,
	output logic signed [pidc_pkg::ProdW-1:0]   prod
);

	logic signed [pidc_pkg::ProdW-1:0] prod_q;

	// register every product; the sequencer picks it up in the following cycle
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

@@ sv/pidc_div.sv @@
module pidc_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pidc_pkg::div_ctl_t                  ctl,
	input  logic signed [pidc_pkg::DivW-1:0]    dividend,
	input  logic [pidc_pkg::StepW-1:0]          divisor,
	output pidc_pkg::div_sts_t                  sts,
	output logic signed [pidc_pkg::DataW-1:0]   quotient
);

	localparam int DW = pidc_pkg::DataW;
	localparam int SW = pidc_pkg::StepW;
	localparam int NW = pidc_pkg::DivW;
	localparam int CntW = $clog2(DW);

	logic                busy_q;
	logic                done_q;
	logic [CntW-1:0]     cnt_q;
	logic [SW-1:0]       rem_q;
	logic [DW-1:0]       acc_q;
	logic [SW-1:0]       dsr_q;
	logic                neg_q;
	logic                ovf_q;
	logic signed [DW-1:0] quot_q;

	logic [NW-1:0] mag;
	logic [SW:0]   trial;
	logic [SW:0]   trial_sub;
	logic          ge;
	logic [DW-1:0] acc_next;
	logic [DW-1:0] q_neg;

	// magnitude of the dividend; one restoring step per cycle
	always_comb begin
		mag       = dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
		trial     = {rem_q, acc_q[DW-1]};
		trial_sub = trial - {1'b0, dsr_q};
		ge        = trial >= {1'b0, dsr_q};
		acc_next  = {acc_q[DW-2:0], ge};
		q_neg     = DW'(-acc_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(DW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: load, iterate, then sign and saturate the quotient
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dsr_q <= divisor;
			neg_q <= dividend[NW-1];
			ovf_q <= mag[NW-2:DW] >= divisor;
			rem_q <= mag[NW-2:DW];
			acc_q <= mag[DW-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[SW-1:0] : trial[SW-1:0];
			acc_q <= acc_next;
			if (cnt_q == '0) begin
				if (ovf_q) begin
					quot_q <= neg_q ? pidc_pkg::SatMin : pidc_pkg::SatMax;
				end else if (neg_q) begin
					quot_q <= (acc_next > DW'(pidc_pkg::SatMin)) ? pidc_pkg::SatMin
						: q_neg;
				end else begin
					quot_q <= acc_next[DW-1] ? pidc_pkg::SatMax : acc_next;
				end
			end
		end
	end

	assign sts.done = done_q;
	assign quotient = quot_q;

endmodule

@@ sv/pid_controller_antiwindup.sv @@
// PID controller with integral anti-windup, signed Q16.16 throughout. A clear
// word (cmd 1) resets the integral, the stored error and the first-step flag
// and gives no result. An update word (cmd 0) gives one result; four products
// go one after another through a single shared 33x33 multiplier, and the
// derivative quotient comes from a serial divider that retires one quotient
// bit per cycle. in_stall stays high from an accepted update word until its
// result is in the output register; a result waiting there holds off only
// the final step of the next update. Configuration writes are always taken
// (cfg_ready is high) and must be made while no update is in flight.
module pid_controller_antiwindup (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 cmd,
	input  logic signed [pidc_pkg::DataW-1:0]    target,
	input  logic signed [pidc_pkg::DataW-1:0]    measured,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [pidc_pkg::DataW-1:0]    drive,
	output logic                                 limited,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pidc_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [pidc_pkg::DataW-1:0]           cfg_data
);

	localparam int DW = pidc_pkg::DataW;
	localparam int SW = pidc_pkg::StepW;
	localparam int MW = pidc_pkg::MulW;
	localparam int PW = pidc_pkg::ProdW;
	localparam int WW = pidc_pkg::WideW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MP,
		S_MI,
		S_MD,
		S_MT,
		S_ACC,
		S_DIV,
		S_SUM
	} state_t;

	state_t state_q;

	logic signed [DW-1:0] gain_p_q, gain_i_q, gain_d_q, out_min_q, out_max_q;
	logic [SW-1:0]        step_time_q;

	logic signed [DW-1:0] integ_q, last_err_q;
	logic                 first_q;

	logic signed [DW-1:0] err_q, diff_q, p_q, t_q, d_q;

	logic                 out_valid_q;
	logic signed [DW-1:0] drive_q;
	logic                 limited_q;

	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] prod;

	pidc_pkg::div_ctl_t   div_ctl;
	pidc_pkg::div_sts_t   div_sts;
	logic signed [DW-1:0] div_quot;

	logic [SW-1:0]        dt;
	logic                 in_take;
	logic                 out_free;

	logic signed [DW:0]   err_raw;
	logic signed [DW:0]   diff_raw;
	logic signed [DW-1:0] inc_sat;
	logic signed [DW:0]   acc_raw;
	logic signed [WW-1:0] sum;
	logic signed [WW-1:0] hi_room, lo_room;
	logic signed [DW-1:0] hi_sat, lo_sat;
	logic                 over_hi, under_lo;

	assign dt       = (step_time_q == '0) ? SW'(1) : step_time_q;
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// operand select for the shared multiplier
	always_comb begin
		case (state_q)
			S_MI: begin
				mul_a = MW'(gain_i_q);
				mul_b = MW'(err_q);
			end
			S_MD: begin
				mul_a = MW'(gain_d_q);
				mul_b = MW'(diff_q);
			end
			S_MT: begin
				mul_a = MW'(t_q);
				mul_b = $signed({1'b0, {(MW-SW-1){1'b0}}, dt});
			end
			default: begin
				mul_a = MW'(gain_p_q);
				mul_b = MW'(err_q);
			end
		endcase
	end

	pidc_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign div_ctl.start = (state_q == S_MT);

	pidc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (prod[pidc_pkg::DivW-1:0]),
		.divisor  (dt),
		.sts      (div_sts),
		.quotient (div_quot)
	);

	// adders around the sequencer
	always_comb begin
		err_raw  = {target[DW-1], target} - {measured[DW-1], measured};
		diff_raw = {err_q[DW-1], err_q} - {last_err_q[DW-1], last_err_q};
		inc_sat  = pidc_pkg::sat_q16(prod);
		acc_raw  = {integ_q[DW-1], integ_q} + {inc_sat[DW-1], inc_sat};
		sum      = WW'(p_q) + WW'(integ_q) + WW'(d_q);
		hi_room  = WW'(out_max_q) - WW'(p_q) - WW'(d_q);
		lo_room  = WW'(out_min_q) - WW'(p_q) - WW'(d_q);
		hi_sat   = pidc_pkg::sat_wide(hi_room);
		lo_sat   = pidc_pkg::sat_wide(lo_room);
		over_hi  = sum > WW'(out_max_q);
		under_lo = sum < WW'(out_min_q);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q    <= '0;
			gain_i_q    <= '0;
			gain_d_q    <= '0;
			step_time_q <= pidc_pkg::RstStepTime;
			out_min_q   <= pidc_pkg::RstOutMin;
			out_max_q   <= pidc_pkg::RstOutMax;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pidc_pkg::REG_GAIN_P:    gain_p_q    <= cfg_data;
				pidc_pkg::REG_GAIN_I:    gain_i_q    <= cfg_data;
				pidc_pkg::REG_GAIN_D:    gain_d_q    <= cfg_data;
				pidc_pkg::REG_STEP_TIME: step_time_q <= cfg_data[SW-1:0];
				pidc_pkg::REG_OUT_MIN:   out_min_q   <= cfg_data;
				pidc_pkg::REG_OUT_MAX:   out_max_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer, controller state and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			integ_q     <= '0;
			last_err_q  <= '0;
			first_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_SUM) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						if (cmd) begin
							integ_q    <= '0;
							last_err_q <= '0;
							first_q    <= 1'b1;
						end else begin
							err_q   <= pidc_pkg::sat_wide(WW'(err_raw));
							state_q <= S_MP;
						end
					end
				end
				S_MP: begin
					diff_q  <= pidc_pkg::sat_wide(WW'(diff_raw));
					state_q <= S_MI;
				end
				S_MI: begin
					p_q     <= pidc_pkg::sat_q16(prod);
					state_q <= S_MD;
				end
				S_MD: begin
					t_q     <= pidc_pkg::sat_q16(prod);
					state_q <= S_MT;
				end
				S_MT: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					integ_q <= pidc_pkg::sat_wide(WW'(acc_raw));
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_sts.done) begin
						d_q     <= first_q ? '0 : div_quot;
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						limited_q   <= over_hi || under_lo;
						if (over_hi) begin
							drive_q <= out_max_q;
						end else if (under_lo) begin
							drive_q <= out_min_q;
						end else begin
							drive_q <= sum[DW-1:0];
						end
						// back-calculate the integral, keep it on its own side of zero
						if (over_hi && integ_q > 0) begin
							integ_q <= hi_sat[DW-1] ? '0 : hi_sat;
						end else if (under_lo && integ_q < 0) begin
							integ_q <= (lo_sat > 0) ? '0 : lo_sat;
						end
						last_err_q <= err_q;
						first_q    <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;
	assign limited   = limited_q;

endmodule

@@ test/pid_controller_antiwindup_tb.sv @@
module pid_controller_antiwindup_tb;

	localparam int   IdleLimit  = 4000;
	localparam int   TailCycles = 60;
	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	typedef struct {
		logic signed [pidc_pkg::DataW-1:0] drive;
		logic                              limited;
	} ctrl_word_t;

	logic                              clk;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_stall;
	logic                              cmd;
	logic signed [pidc_pkg::DataW-1:0] target;
	logic signed [pidc_pkg::DataW-1:0] measured;
	logic                              out_valid;
	logic                              out_stall;
	logic signed [pidc_pkg::DataW-1:0] drive;
	logic                              limited;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [pidc_pkg::CfgIdxW-1:0]      cfg_index;
	logic [pidc_pkg::DataW-1:0]        cfg_data;

	// controller copy: gains, period, limits and loop state
	longint kp, ki, kd, period, lim_lo, lim_hi;
	longint acc_i, prev_err;
	bit     fresh;

	ctrl_word_t expected_outs[$];
	ctrl_word_t head;
	int         errors;
	int         results_seen;
	int         idle_cycles;
	bit         steady;

	pid_controller_antiwindup uut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint clip32(input longint v);
		if (v > longint'(pidc_pkg::SatMax)) begin
			return longint'(pidc_pkg::SatMax);
		end
		if (v < longint'(pidc_pkg::SatMin)) begin
			return longint'(pidc_pkg::SatMin);
		end
		return v;
	endfunction

	// one controller update: returns the clamped drive and the limit flag
	function automatic ctrl_word_t pid_update(
			input logic signed [pidc_pkg::DataW-1:0] tgt, meas);
		longint     dt, e, p, t, d, sum;
		ctrl_word_t r;
		dt = (period == 0) ? 1 : period;
		e = clip32(longint'(tgt) - longint'(meas));
		p = clip32((kp * e) >>> 16);
		t = clip32((ki * e) >>> 16);
		acc_i = clip32(acc_i + clip32((t * dt) >>> 16));
		if (fresh) begin
			d = 0;
			fresh = 1'b0;
		end else begin
			d = clip32((kd * clip32(e - prev_err)) / dt);
		end
		sum = p + acc_i + d;
		// clamp, upper limit checked first so with crossed limits a sum above out_max resolves to out_max
		r.limited = 1'b1;
		if (sum > lim_hi) begin
			r.drive = lim_hi[pidc_pkg::DataW-1:0];
		end else if (sum < lim_lo) begin
			r.drive = lim_lo[pidc_pkg::DataW-1:0];
		end else begin
			r.drive   = sum[pidc_pkg::DataW-1:0];
			r.limited = 1'b0;
		end
		// back-calculate the integral and keep it on its own side of zero
		if (sum > lim_hi && acc_i > 0) begin
			acc_i = clip32(lim_hi - p - d);
			if (acc_i < 0) begin
				acc_i = 0;
			end
		end else if (sum < lim_lo && acc_i < 0) begin
			acc_i = clip32(lim_lo - p - d);
			if (acc_i > 0) begin
				acc_i = 0;
			end
		end
		prev_err = e;
		return r;
	endfunction

	task automatic report_mismatch(input string what,
			input logic signed [pidc_pkg::DataW-1:0] got, want);
		$display("result %0d: %s got %0d expected %0d", results_seen, what, got, want);
		errors++;
	endtask

	// track config writes and accepted words, check each result word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp       = 0;
			ki       = 0;
			kd       = 0;
			period   = longint'(pidc_pkg::RstStepTime);
			lim_lo   = longint'(pidc_pkg::RstOutMin);
			lim_hi   = longint'(pidc_pkg::RstOutMax);
			acc_i    = 0;
			prev_err = 0;
			fresh    = 1'b1;
		end else begin
			idle_cycles++;
			if (cfg_valid && cfg_ready) begin
				idle_cycles = 0;
				case (pidc_pkg::reg_idx_t'(cfg_index))
					pidc_pkg::REG_GAIN_P:    kp = longint'($signed(cfg_data));
					pidc_pkg::REG_GAIN_I:    ki = longint'($signed(cfg_data));
					pidc_pkg::REG_GAIN_D:    kd = longint'($signed(cfg_data));
					pidc_pkg::REG_STEP_TIME:
						period = longint'(cfg_data[pidc_pkg::StepW-1:0]);
					pidc_pkg::REG_OUT_MIN:   lim_lo = longint'($signed(cfg_data));
					pidc_pkg::REG_OUT_MAX:   lim_hi = longint'($signed(cfg_data));
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				idle_cycles = 0;
				results_seen++;
				if (expected_outs.size() == 0) begin
					report_mismatch("word with none expected, drive", drive, '0);
				end else begin
					head = expected_outs.pop_front();
					if (drive !== head.drive) begin
						report_mismatch("drive", drive, head.drive);
					end
					if (limited !== head.limited) begin
						report_mismatch("limited", {31'b0, limited}, {31'b0, head.limited});
					end
				end
			end
			if (in_valid && !in_stall) begin
				idle_cycles = 0;
				if (cmd == CMD_CLEAR) begin
					acc_i    = 0;
					prev_err = 0;
					fresh    = 1'b1;
				end else begin
					expected_outs.push_back(pid_update(target, measured));
				end
			end
		end
	end

	// end the run when nothing moves for too long
	initial begin
		wait (idle_cycles >= IdleLimit);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// stall the result side in random runs
	initial begin
		int run;
		run = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (steady) begin
				out_stall <= 1'b0;
				run = 0;
			end else if (run > 0) begin
				run--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 35);
				run = idle_len();
			end
		end
	end

	function automatic logic signed [pidc_pkg::DataW-1:0] fx(input int whole);
		return whole <<< 16;
	endfunction

	function automatic logic signed [pidc_pkg::DataW-1:0] rand_q16(input int lo_sh, hi_sh);
		return $signed($urandom()) >>> $urandom_range(lo_sh, hi_sh);
	endfunction

	function automatic logic signed [pidc_pkg::DataW-1:0] pick_edge();
		case ($urandom_range(0, 3))
			0: return pidc_pkg::SatMin;
			1: return pidc_pkg::SatMax;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	function automatic logic signed [pidc_pkg::DataW-1:0] rand_field();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			return pick_edge();
		end
		if (r < 25) begin
			return $urandom();
		end
		return rand_q16(6, 14);
	endfunction

	function automatic logic signed [pidc_pkg::DataW-1:0] rand_gain();
		if ($urandom_range(0, 9) == 0) begin
			return pick_edge();
		end
		return rand_q16(8, 16);
	endfunction

	// present one input word after a random gap unless steady, hold it until taken
	task automatic send_word(input logic op,
			input logic signed [pidc_pkg::DataW-1:0] tgt, meas);
		int gap;
		gap = steady ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		target   <= tgt;
		measured <= meas;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid and wait until every expected word has come back
	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_outs.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input pidc_pkg::reg_idx_t idx,
			input logic [pidc_pkg::DataW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure(input logic [pidc_pkg::DataW-1:0] gp, gi, gd, st, lo, hi);
		quiesce();
		write_reg(pidc_pkg::REG_GAIN_P, gp);
		write_reg(pidc_pkg::REG_GAIN_I, gi);
		write_reg(pidc_pkg::REG_GAIN_D, gd);
		write_reg(pidc_pkg::REG_STEP_TIME, st);
		write_reg(pidc_pkg::REG_OUT_MIN, lo);
		write_reg(pidc_pkg::REG_OUT_MAX, hi);
		cfg_valid <= 1'b0;
	endtask

	// zero gains out of reset give a zero drive
	task automatic test_reset_config();
		send_word(CMD_UPDATE, fx(5), fx(2));
		send_word(CMD_UPDATE, fx(-3), fx(4));
	endtask

	// saturating error, gains, period and limits
	task automatic test_field_extremes();
		configure(pidc_pkg::SatMax, pidc_pkg::SatMin, pidc_pkg::SatMax, 32'hffff_ffff,
			pidc_pkg::SatMin, pidc_pkg::SatMax);
		send_word(CMD_UPDATE, pidc_pkg::SatMax, pidc_pkg::SatMin);
		send_word(CMD_UPDATE, pidc_pkg::SatMin, pidc_pkg::SatMax);
		send_word(CMD_UPDATE, pidc_pkg::SatMax, pidc_pkg::SatMax);
		send_word(CMD_UPDATE, '1, '0);
		configure(pidc_pkg::SatMin, pidc_pkg::SatMax, pidc_pkg::SatMin, 32'd1,
			fx(-1), fx(1));
		send_word(CMD_UPDATE, fx(3), '0);
		send_word(CMD_UPDATE, '0, fx(3));
	endtask

	// clear drops the integral and the stored error; next D is zero
	task automatic test_clear();
		configure(fx(1), 32'h0000_8000, 32'h0000_4000, 32'd655, fx(-100), fx(100));
		send_word(CMD_UPDATE, fx(10), fx(7));
		send_word(CMD_UPDATE, fx(10), fx(8));
		send_word(CMD_CLEAR, $urandom(), $urandom());
		send_word(CMD_UPDATE, fx(10), fx(9));
		send_word(CMD_CLEAR, pidc_pkg::SatMin, pidc_pkg::SatMax);
		send_word(CMD_UPDATE, fx(2), fx(-2));
	endtask

	// a zero period acts as the smallest period
	task automatic test_zero_period();
		configure('0, fx(1), fx(1), '0, pidc_pkg::SatMin, pidc_pkg::SatMax);
		send_word(CMD_UPDATE, fx(1), '0);
		send_word(CMD_UPDATE, fx(2), '0);
		send_word(CMD_UPDATE, '0, fx(1));
	endtask

	// out_min above out_max: a sum above out_max gets out_max, any other gets out_min
	task automatic test_crossed_limits();
		configure(fx(1), '0, '0, fx(1), fx(5), fx(-5));
		send_word(CMD_UPDATE, fx(10), '0);
		send_word(CMD_UPDATE, '0, fx(10));
		send_word(CMD_UPDATE, '0, '0);
	endtask

	// back-calculation on both sides, floored and capped at zero
	task automatic test_antiwindup();
		configure(fx(1), fx(1), '0, fx(1), fx(-10), fx(10));
		send_word(CMD_CLEAR, '0, '0);
		send_word(CMD_UPDATE, fx(4), '0);
		send_word(CMD_UPDATE, fx(20), '0);
		send_word(CMD_UPDATE, '0, fx(4));
		send_word(CMD_UPDATE, '0, fx(20));
		send_word(CMD_UPDATE, fx(12), '0);
	endtask

	// random settings, setpoint tracking runs with noise and clears
	task automatic test_random_traffic();
		logic signed [pidc_pkg::DataW-1:0] lo, hi, tmp, sp;
		logic [pidc_pkg::DataW-1:0]        st;
		int                                mode;
		int                                r;
		for (int ph = 0; ph < 10; ph++) begin
			lo = rand_q16(6, 14);
			hi = rand_q16(6, 14);
			mode = $urandom_range(0, 9);
			if (mode < 2) begin
				lo = pidc_pkg::SatMin;
				hi = pidc_pkg::SatMax;
			end else if ((mode == 2) ? (lo < hi) : (lo > hi)) begin
				tmp = lo;
				lo  = hi;
				hi  = tmp;
			end
			case ($urandom_range(0, 5))
				0: st = '0;
				1: st = 32'd1;
				2: st = 32'h7fff_ffff;
				3: st = 32'd655;
				default: st = $urandom_range(1, 32'h0004_0000);
			endcase
			st[pidc_pkg::DataW-1] = $urandom_range(0, 1);
			configure(rand_gain(), rand_gain(), rand_gain(), st, lo, hi);
			steady = (ph % 4 == 3);
			sp = rand_q16(4, 12);
			for (int n = 0; n < 60; n++) begin
				r = $urandom_range(0, 99);
				if (r < 5) begin
					send_word(CMD_CLEAR, $urandom(), $urandom());
				end else if (r < 20) begin
					send_word(CMD_UPDATE, rand_field(), rand_field());
				end else begin
					if ($urandom_range(0, 9) == 0) begin
						sp = rand_q16(4, 12);
					end
					send_word(CMD_UPDATE, sp, sp - rand_q16(10, 20));
				end
				// hold the sender until the result side runs dry
				if ($urandom_range(0, 49) == 0) begin
					quiesce();
				end
			end
			steady = 1'b0;
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		cmd       <= CMD_UPDATE;
		target    <= '0;
		measured  <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= pidc_pkg::REG_GAIN_P;
		cfg_data  <= '0;
		steady = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_field_extremes();
		test_clear();
		test_zero_period();
		test_crossed_limits();
		test_antiwindup();
		test_random_traffic();
		quiesce();
		repeat (TailCycles) @(posedge clk);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
